// ===== hw/rtl/tbps_pkg.sv =====
// shared types and constants for the token bucket packet shaper
`timescale 1ns / 1ps

package tbps_pkg;

  // field widths
  localparam int RATE_W  = 16;
  localparam int SIZE_W  = 16;
  localparam int TOKEN_W = 34;
  localparam int SUM_W   = TOKEN_W + 1;
  localparam int CNT_W   = 64;

  // one Mbps is 131072 bytes per second, the cap is twice that
  localparam int REFILL_SHIFT = 17;
  localparam int CAP_SHIFT    = REFILL_SHIFT + 1;
  localparam int REFILL_W     = RATE_W + REFILL_SHIFT;

  // stream widths
  localparam int IN_TDATA_W  = SIZE_W;
  localparam int OUT_USED_W  = 1 + TOKEN_W + 4 * CNT_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  // item kinds
  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [SIZE_W-1:0] size;
  } item_t;

  typedef struct packed {
    logic               allowed;
    logic [TOKEN_W-1:0] tokens;
    logic [CNT_W-1:0]   sent_pkts;
    logic [CNT_W-1:0]   drop_pkts;
    logic [CNT_W-1:0]   sent_bytes;
    logic [CNT_W-1:0]   drop_bytes;
  } result_t;

  typedef struct packed {
    logic [RATE_W-1:0]  rate;
    logic [TOKEN_W-1:0] tokens;
  } bucket_stat_t;

endpackage

// ===== hw/rtl/tbps_in_reg.sv =====
// input register stage holding one accepted beat
`timescale 1ns / 1ps

module tbps_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  tbps_pkg::item_t in_item,
  output logic            in_ready,
  input  logic            adv,
  output logic            s1_valid,
  output tbps_pkg::item_t s1_item
);
  import tbps_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  // take a new beat when empty or when the held one moves on
  assign in_ready = !valid_r || adv;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// ===== hw/rtl/tbps_bucket.sv =====
// bucket state, rate register, counters and the admission decision
`timescale 1ns / 1ps

module tbps_bucket (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [tbps_pkg::RATE_W-1:0]   cfg_wr_data,
  input  logic                          fire,
  input  tbps_pkg::item_t               item,
  output tbps_pkg::result_t             result,
  output tbps_pkg::bucket_stat_t        stat
);
  import tbps_pkg::*;

  logic [RATE_W-1:0]   rate_r;
  logic [TOKEN_W-1:0]  tokens_r, tokens_nxt;
  logic [CNT_W-1:0]    sent_pkts_r, sent_pkts_nxt;
  logic [CNT_W-1:0]    drop_pkts_r, drop_pkts_nxt;
  logic [CNT_W-1:0]    sent_bytes_r, sent_bytes_nxt;
  logic [CNT_W-1:0]    drop_bytes_r, drop_bytes_nxt;
  logic                allowed;

  logic [REFILL_W-1:0] refill;
  logic [TOKEN_W-1:0]  cap;
  logic [TOKEN_W-1:0]  cfg_cap;
  logic [SUM_W-1:0]    sum;
  logic [TOKEN_W-1:0]  size_ext;
  logic [CNT_W-1:0]    size_cnt;

  // refill per tick and bucket cap are shifts of the rate
  assign refill   = {rate_r, {REFILL_SHIFT{1'b0}}};
  assign cap      = {rate_r, {CAP_SHIFT{1'b0}}};
  assign cfg_cap  = {cfg_wr_data, {CAP_SHIFT{1'b0}}};
  assign sum      = {1'b0, tokens_r} + {{(SUM_W-REFILL_W){1'b0}}, refill};
  assign size_ext = {{(TOKEN_W-SIZE_W){1'b0}}, item.size};
  assign size_cnt = {{(CNT_W-SIZE_W){1'b0}}, item.size};

  // admission decision and next state
  always_comb begin
    allowed        = 1'b0;
    tokens_nxt     = tokens_r;
    sent_pkts_nxt  = sent_pkts_r;
    drop_pkts_nxt  = drop_pkts_r;
    sent_bytes_nxt = sent_bytes_r;
    drop_bytes_nxt = drop_bytes_r;
    priority if (item.cmd == CMD_TICK) begin
      // saturating refill
      if (sum > {1'b0, cap}) begin
        tokens_nxt = cap;
      end else begin
        tokens_nxt = sum[TOKEN_W-1:0];
      end
    end else if (rate_r == '0) begin
      // unlimited: pass everything, touch nothing
      allowed = 1'b1;
    end else if (tokens_r >= size_ext) begin
      allowed        = 1'b1;
      tokens_nxt     = tokens_r - size_ext;
      sent_pkts_nxt  = sent_pkts_r + 64'd1;
      sent_bytes_nxt = sent_bytes_r + size_cnt;
    end else begin
      drop_pkts_nxt  = drop_pkts_r + 64'd1;
      drop_bytes_nxt = drop_bytes_r + size_cnt;
    end
  end

  // state update; a rate write refills the bucket
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r       <= '0;
      tokens_r     <= '0;
      sent_pkts_r  <= '0;
      drop_pkts_r  <= '0;
      sent_bytes_r <= '0;
      drop_bytes_r <= '0;
    end else begin
      priority if (cfg_wr_en) begin
        rate_r   <= cfg_wr_data;
        tokens_r <= cfg_cap;
      end else if (fire) begin
        tokens_r     <= tokens_nxt;
        sent_pkts_r  <= sent_pkts_nxt;
        drop_pkts_r  <= drop_pkts_nxt;
        sent_bytes_r <= sent_bytes_nxt;
        drop_bytes_r <= drop_bytes_nxt;
      end
    end
  end

  // result fields show the state after this item
  assign result.allowed    = allowed;
  assign result.tokens     = tokens_nxt;
  assign result.sent_pkts  = sent_pkts_nxt;
  assign result.drop_pkts  = drop_pkts_nxt;
  assign result.sent_bytes = sent_bytes_nxt;
  assign result.drop_bytes = drop_bytes_nxt;

  assign stat.rate   = rate_r;
  assign stat.tokens = tokens_r;

endmodule

// ===== hw/rtl/token_bucket_packet_shaper.sv =====
// top level of the token bucket packet shaper
`timescale 1ns / 1ps

// Token bucket packet shaper.
// Input stream: in_tuser is the item kind (0 packet request, 1 one-second
// refill tick), in_tdata[15:0] the packet size in bytes.
// Output stream: one beat per input beat, in order, carrying the verdict,
// the tokens left and the four wrapping sent/dropped counters.
// Configuration: cfg_wr_en with cfg_wr_data writes the rate in Mbps and
// fills the bucket to twice rate*131072 bytes; a rate of zero is unlimited.
// Write the rate only while no beat is in flight.
// Path: two register stages, the input register and the result register; the
// decision, the saturating refill and the 64-bit counter adds all settle
// between the two registers. Throughput: one beat per cycle unless the
// receiver stalls (out_tready low).
// Reset (rst_n low, synchronous): both stages empty, rate zero, bucket and
// counters zero.
// When the receiver stalls, the result register holds its beat and the
// input register still takes one more beat if it is empty; after that in_tready drops.
module token_bucket_packet_shaper (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tbps_pkg::IN_TDATA_W-1:0]    in_tdata,   // packet_bytes[15:0]
  input  logic                               in_tuser,   // cmd
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // allowed[0], tokens_left[34:1], sent_packets[98:35],
  // dropped_packets[162:99], sent_bytes[226:163], dropped_bytes[290:227],
  // zero pad[295:291]
  output logic [tbps_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // configuration
  input  logic                               cfg_wr_en,
  input  logic [tbps_pkg::RATE_W-1:0]        cfg_wr_data
);
  import tbps_pkg::*;

  item_t        in_item;
  item_t        s1_item;
  logic         s1_valid;
  logic         s1_adv;
  result_t      res;
  result_t      out_res_r;
  logic         out_valid_r, out_valid_nxt;
  bucket_stat_t stat;

  assign in_item.cmd  = in_tuser;
  assign in_item.size = in_tdata[SIZE_W-1:0];

  // stage one moves on when the result register is free or draining
  assign s1_adv = s1_valid && (!out_valid_r || out_tready);

  tbps_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_item  (in_item),
    .in_ready (in_tready),
    .adv      (s1_adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  tbps_bucket u_bucket (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (s1_adv),
    .item        (s1_item),
    .result      (res),
    .stat        (stat)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  // pack result beat, first field lowest
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}},
                       out_res_r.drop_bytes,
                       out_res_r.sent_bytes,
                       out_res_r.drop_pkts,
                       out_res_r.sent_pkts,
                       out_res_r.tokens,
                       out_res_r.allowed};

  // bucket never holds more than its cap
  a_tokens_capped: assert property (@(posedge clk) disable iff (!rst_n)
    stat.tokens <= {stat.rate, {CAP_SHIFT{1'b0}}})
    else $error("token count above bucket cap");

  // input only stalls when the result register is full
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty result register");

  // a tick never yields an admitted verdict
  a_tick_not_allowed: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_item.cmd == CMD_TICK) |=> !out_tdata[0])
    else $error("tick produced allowed verdict");

endmodule
